/* rtl/vector_pan_tilt_angles_assert.svh */
// assertion macros for the vector pan/tilt angle block
`ifndef VECTOR_PAN_TILT_ANGLES_ASSERT_SVH
`define VECTOR_PAN_TILT_ANGLES_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, clocked on clk, disabled in reset
`define VPTA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vpta: same-cycle check failed");
// next-cycle implication, clocked on clk, disabled in reset
`define VPTA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vpta: next-cycle check failed");
`else
`define VPTA_ASSERT_IMP(lbl, ante, cons)
`define VPTA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* rtl/vpta_pkg.sv */
// constants, types and tables of the vector pan/tilt angle block
package vpta_pkg;

    localparam int COMPONENT_WIDTH = 24;
    localparam int CORDIC_STEPS    = 16;
    localparam int ATAN_LEN        = 24;
    localparam int NUM_STEPS       = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

    // components are scaled so that full scale sits just under bit 59
    localparam int SCALE_TOP = 59;
    localparam int GUARD     = SCALE_TOP - COMPONENT_WIDTH;
    localparam int DATA_W    = 64;
    localparam int EXT_W     = DATA_W - SCALE_TOP;

    localparam int ANGLE_W = 32;
    localparam int BAU_W   = 16;

    localparam int GAIN_W = 30;
    localparam int LO_W   = 30;
    localparam int HI_W   = DATA_W - LO_W;
    localparam int LOP_W  = LO_W + GAIN_W;

    typedef logic signed [DATA_W-1:0]          data_t;
    typedef logic        [ANGLE_W-1:0]         angle_t;
    typedef logic signed [BAU_W-1:0]           bau_t;
    typedef logic signed [COMPONENT_WIDTH-1:0] comp_t;

    localparam angle_t ANGLE_ZERO = '0;
    localparam angle_t ANGLE_PI   = angle_t'(64'h8000_0000);
    localparam angle_t BAU_ROUND  = angle_t'(64'h0000_8000);
    localparam bau_t   TILT_MAX   = bau_t'(16384);

    // inverse cordic gain in q30
    localparam logic [GAIN_W-1:0] GAIN_Q30 = GAIN_W'(652032874);
    localparam logic [LOP_W:0]    LO_ROUND = (LOP_W + 1)'(64'h2000_0000);

    // round(atan(2^-i) * 2^31 / pi)
    function automatic angle_t atan_entry(input int unsigned i);
        angle_t r;
        case (i)
            0:       r = 32'd536870912;
            1:       r = 32'd316933406;
            2:       r = 32'd167458907;
            3:       r = 32'd85004756;
            4:       r = 32'd42667331;
            5:       r = 32'd21354465;
            6:       r = 32'd10680350;
            7:       r = 32'd5340245;
            8:       r = 32'd2670163;
            9:       r = 32'd1335087;
            10:      r = 32'd667544;
            11:      r = 32'd333772;
            12:      r = 32'd166886;
            13:      r = 32'd83443;
            14:      r = 32'd41722;
            15:      r = 32'd20861;
            16:      r = 32'd10430;
            17:      r = 32'd5215;
            18:      r = 32'd2608;
            19:      r = 32'd1304;
            20:      r = 32'd652;
            21:      r = 32'd326;
            22:      r = 32'd163;
            23:      r = 32'd81;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/vpta_in_if.sv */
// input channel: one vector word
interface vpta_in_if;
    logic                  valid;
    logic                  ready;
    vpta_pkg::comp_t       vec_x;
    vpta_pkg::comp_t       vec_y;
    vpta_pkg::comp_t       vec_z;

    modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
    modport sink   (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

/* rtl/vpta_out_if.sv */
// output channel: one angle pair word
interface vpta_out_if;
    logic                  valid;
    logic                  ready;
    vpta_pkg::bau_t        pan_angle;
    vpta_pkg::bau_t        tilt_angle;

    modport source (output valid, output pan_angle, output tilt_angle, input ready);
    modport sink   (input valid, input pan_angle, input tilt_angle, output ready);
endinterface

/* rtl/vector_pan_tilt_angles.sv */
// top level: pipelined cordic pan/tilt angles of a 3d vector
//
//  channel   direction  fields                          handshake
//  vector    in         vec_x, vec_y, vec_z (s24 each)  valid/ready
//  angles    out        pan_angle, tilt_angle (s16)     valid/ready
//
//  one word accepted per cycle unless the pipe is full and angles.ready is low;
//  each word passes in order: input scaling, one register per pan cordic step,
//  two gain multiply stages, one register per tilt cordic step, output register
//  rst_n clears only the valid bits; the payload registers keep whatever they hold
//  every stage moves on when it is empty or its successor moves, so bubbles are
//  squeezed out and vector.ready stays high until every stage holds a word
//  with angles.ready low; nothing is dropped or repeated under stalls
module vector_pan_tilt_angles (
    input  logic       clk,
    input  logic       rst_n,
    vpta_in_if.sink    vector,
    vpta_out_if.source angles
);

`include "vector_pan_tilt_angles_assert.svh"

    localparam int N      = vpta_pkg::NUM_STEPS;
    localparam int NSTAGE = 2 * N + 4;
    localparam int MUL1   = N + 1;          // stage index of the low gain product
    localparam int TILT0  = N + 2;          // stage index of the length/tilt entry
    localparam int LAST   = NSTAGE - 1;     // output register
    localparam int DW     = vpta_pkg::DATA_W;
    localparam int AW     = vpta_pkg::ANGLE_W;

    // ------------------------------------------------------------------
    // flow control: per-stage valid bits and enables
    // ------------------------------------------------------------------
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE:0]   stage_en;

    assign stage_en[NSTAGE] = angles.ready;
    for (genvar k = 0; k < NSTAGE; k++) begin : g_en
        // a stage loads when it is empty or its word moves on
        assign stage_en[k] = !valid_reg[k] || stage_en[k+1];
    end

    assign valid_next = {valid_reg[NSTAGE-2:0], vector.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= (valid_next & stage_en[NSTAGE-1:0])
                       | (valid_reg & ~stage_en[NSTAGE-1:0]);
        end
    end

    assign vector.ready = stage_en[0];

    // ------------------------------------------------------------------
    // pan pass: stage 0 scales and folds x into the right half plane,
    // stages 1..N each run one vectoring step
    // ------------------------------------------------------------------
    vpta_pkg::data_t  px_reg    [0:N];
    vpta_pkg::data_t  py_reg    [0:N];
    vpta_pkg::angle_t pa_reg    [0:N];
    vpta_pkg::data_t  pz_reg    [0:N];
    logic             pzxy_reg  [0:N];   // x and y both zero
    logic             pzall_reg [0:N];   // whole vector zero

    vpta_pkg::data_t  px_next   [0:N];
    vpta_pkg::data_t  py_next   [0:N];
    vpta_pkg::angle_t pa_next   [0:N];

    vpta_pkg::data_t  in_x_wide;
    vpta_pkg::data_t  in_y_wide;
    vpta_pkg::data_t  in_z_wide;

    // sign extend and move the component up to the common scale
    assign in_x_wide = {{vpta_pkg::EXT_W{vector.vec_x[vpta_pkg::COMPONENT_WIDTH-1]}},
                        vector.vec_x, {vpta_pkg::GUARD{1'b0}}};
    assign in_y_wide = {{vpta_pkg::EXT_W{vector.vec_y[vpta_pkg::COMPONENT_WIDTH-1]}},
                        vector.vec_y, {vpta_pkg::GUARD{1'b0}}};
    assign in_z_wide = {{vpta_pkg::EXT_W{vector.vec_z[vpta_pkg::COMPONENT_WIDTH-1]}},
                        vector.vec_z, {vpta_pkg::GUARD{1'b0}}};

    always_comb
    begin
        // left half plane: rotate by pi first
        if (in_x_wide < 0)
        begin
            px_next[0] = -in_x_wide;
            py_next[0] = -in_y_wide;
            pa_next[0] = vpta_pkg::ANGLE_PI;
        end
        else
        begin
            px_next[0] = in_x_wide;
            py_next[0] = in_y_wide;
            pa_next[0] = vpta_pkg::ANGLE_ZERO;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            px_reg[0]    <= px_next[0];
            py_reg[0]    <= py_next[0];
            pa_reg[0]    <= pa_next[0];
            pz_reg[0]    <= in_z_wide;
            pzxy_reg[0]  <= (in_x_wide == '0) && (in_y_wide == '0);
            pzall_reg[0] <= (in_x_wide == '0) && (in_y_wide == '0) && (in_z_wide == '0);
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_pan
        vpta_pkg::data_t dx;
        vpta_pkg::data_t dy;

        assign dx = py_reg[k] >>> k;
        assign dy = px_reg[k] >>> k;

        always_comb
        begin
            // rotate toward the x axis, both updates from the old pair
            if (!py_reg[k][DW-1])
            begin
                px_next[k+1] = px_reg[k] + dx;
                py_next[k+1] = py_reg[k] - dy;
                pa_next[k+1] = pa_reg[k] + vpta_pkg::atan_entry(k);
            end
            else
            begin
                px_next[k+1] = px_reg[k] - dx;
                py_next[k+1] = py_reg[k] + dy;
                pa_next[k+1] = pa_reg[k] - vpta_pkg::atan_entry(k);
            end
        end

        always_ff @(posedge clk)
        begin
            if (stage_en[k+1])
            begin
                px_reg[k+1]    <= px_next[k+1];
                py_reg[k+1]    <= py_next[k+1];
                pa_reg[k+1]    <= pa_next[k+1];
                pz_reg[k+1]    <= pz_reg[k];
                pzxy_reg[k+1]  <= pzxy_reg[k];
                pzall_reg[k+1] <= pzall_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // gain compensation: length = x * K, K in q30, split into a low and a
    // high partial product over two stages, rounded half up
    // ------------------------------------------------------------------
    logic [vpta_pkg::LOP_W-1:0]  lo_prod_reg;
    logic [vpta_pkg::HI_W-1:0]   hi_reg;
    vpta_pkg::data_t             mz_reg;
    vpta_pkg::bau_t              mpan_reg;
    logic                        mzall_reg;

    logic [vpta_pkg::LO_W-1:0]   lo_part;
    logic [vpta_pkg::HI_W-1:0]   hi_part;
    vpta_pkg::angle_t            pan_rnd;
    vpta_pkg::bau_t              pan_next;

    // a zero horizontal part gives zero pan and zero length
    assign lo_part  = pzxy_reg[N] ? '0 : px_reg[N][vpta_pkg::LO_W-1:0];
    assign hi_part  = pzxy_reg[N] ? '0 : px_reg[N][DW-1:vpta_pkg::LO_W];
    assign pan_rnd  = pa_reg[N] + vpta_pkg::BAU_ROUND;
    assign pan_next = pzxy_reg[N] ? '0 : vpta_pkg::bau_t'(pan_rnd[AW-1:AW-vpta_pkg::BAU_W]);

    always_ff @(posedge clk)
    begin
        if (stage_en[MUL1])
        begin
            lo_prod_reg <= lo_part * vpta_pkg::GAIN_Q30;
            hi_reg      <= hi_part;
            mz_reg      <= pz_reg[N];
            mpan_reg    <= pan_next;
            mzall_reg   <= pzall_reg[N];
        end
    end

    logic [vpta_pkg::HI_W+vpta_pkg::GAIN_W-1:0] hi_prod;
    logic [vpta_pkg::LOP_W:0]                   lo_rnd;
    logic [vpta_pkg::GAIN_W:0]                  lo_term;
    logic [DW-1:0]                              len_sum;

    assign hi_prod = hi_reg * vpta_pkg::GAIN_Q30;
    assign lo_rnd  = {1'b0, lo_prod_reg} + vpta_pkg::LO_ROUND;
    assign lo_term = lo_rnd[vpta_pkg::LOP_W:vpta_pkg::LO_W];
    assign len_sum = hi_prod[DW-1:0] + DW'(lo_term);

    // ------------------------------------------------------------------
    // tilt pass: stage TILT0 holds (length, z), the next N stages each run
    // one vectoring step
    // ------------------------------------------------------------------
    vpta_pkg::data_t  tx_reg    [0:N];
    vpta_pkg::data_t  ty_reg    [0:N];
    vpta_pkg::angle_t ta_reg    [0:N];
    vpta_pkg::bau_t   tpan_reg  [0:N];
    logic             tzall_reg [0:N];

    vpta_pkg::data_t  tx_next   [1:N];
    vpta_pkg::data_t  ty_next   [1:N];
    vpta_pkg::angle_t ta_next   [1:N];

    always_ff @(posedge clk)
    begin
        if (stage_en[TILT0])
        begin
            tx_reg[0]    <= $signed(len_sum);
            ty_reg[0]    <= mz_reg;
            ta_reg[0]    <= vpta_pkg::ANGLE_ZERO;
            tpan_reg[0]  <= mpan_reg;
            tzall_reg[0] <= mzall_reg;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_tilt
        vpta_pkg::data_t dx;
        vpta_pkg::data_t dy;

        assign dx = ty_reg[k] >>> k;
        assign dy = tx_reg[k] >>> k;

        always_comb
        begin
            if (!ty_reg[k][DW-1])
            begin
                tx_next[k+1] = tx_reg[k] + dx;
                ty_next[k+1] = ty_reg[k] - dy;
                ta_next[k+1] = ta_reg[k] + vpta_pkg::atan_entry(k);
            end
            else
            begin
                tx_next[k+1] = tx_reg[k] - dx;
                ty_next[k+1] = ty_reg[k] + dy;
                ta_next[k+1] = ta_reg[k] - vpta_pkg::atan_entry(k);
            end
        end

        always_ff @(posedge clk)
        begin
            if (stage_en[TILT0+k+1])
            begin
                tx_reg[k+1]    <= tx_next[k+1];
                ty_reg[k+1]    <= ty_next[k+1];
                ta_reg[k+1]    <= ta_next[k+1];
                tpan_reg[k+1]  <= tpan_reg[k];
                tzall_reg[k+1] <= tzall_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // output register: round tilt, clamp to +-pi/2, zero vector gives zero
    // ------------------------------------------------------------------
    vpta_pkg::bau_t   pan_out_reg;
    vpta_pkg::bau_t   tilt_out_reg;
    logic             zall_out_reg;

    vpta_pkg::angle_t tilt_rnd;
    vpta_pkg::bau_t   tilt_raw;
    vpta_pkg::bau_t   tilt_next;

    assign tilt_rnd = ta_reg[N] + vpta_pkg::BAU_ROUND;
    assign tilt_raw = vpta_pkg::bau_t'(tilt_rnd[AW-1:AW-vpta_pkg::BAU_W]);

    always_comb
    begin
        if (tzall_reg[N])
        begin
            tilt_next = '0;
        end
        else if (tilt_raw > vpta_pkg::TILT_MAX)
        begin
            tilt_next = vpta_pkg::TILT_MAX;
        end
        else if (tilt_raw < -vpta_pkg::TILT_MAX)
        begin
            tilt_next = -vpta_pkg::TILT_MAX;
        end
        else
        begin
            tilt_next = tilt_raw;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[LAST])
        begin
            pan_out_reg  <= tpan_reg[N];
            tilt_out_reg <= tilt_next;
            zall_out_reg <= tzall_reg[N];
        end
    end

    assign angles.valid      = valid_reg[LAST];
    assign angles.pan_angle  = pan_out_reg;
    assign angles.tilt_angle = tilt_out_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `VPTA_ASSERT_IMP(a_tilt_range, valid_reg[LAST],
        (tilt_out_reg <= vpta_pkg::TILT_MAX) && (tilt_out_reg >= -vpta_pkg::TILT_MAX))
    `VPTA_ASSERT_IMP(a_zero_vector, valid_reg[LAST] && zall_out_reg,
        (pan_out_reg == '0) && (tilt_out_reg == '0))
    `VPTA_ASSERT_IMP(a_pan_x_nonneg, valid_reg[N], !px_reg[N][DW-1])
    `VPTA_ASSERT_IMP(a_full_when_blocked, !stage_en[0],
        (valid_reg == {NSTAGE{1'b1}}) && !angles.ready)

endmodule
